FILE: hw/rtl/tks_pkg.sv
`timescale 1ns / 1ps

package tks_pkg;

  localparam int DEPTH_DEF   = 5;
  localparam int ID_BITS_DEF = 16;
  localparam int SCORE_W     = 32;
  localparam int KIND_W      = 2;
  localparam int RANK_W      = 3;
  localparam int STATUS_W    = 3;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_INSERTED   = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_RAISED     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_KEPT       = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_DROPPED    = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_READ_OK    = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_READ_EMPTY = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_CLEARED    = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_EVICT,
    S_SHIFT,
    S_PLACE
  } state_e;

  // Outcome of comparing one stored entry against the key being inserted.
  typedef struct packed {
    logic id_eq;  // stored id equals the key id
    logic ge;     // stored score is at least the key score
    logic gt;     // key score is strictly above the stored score
  } cmp_t;

endpackage

FILE: hw/rtl/tks_cmp.sv
`timescale 1ns / 1ps

module tks_cmp import tks_pkg::*; #(
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic [ID_BITS-1:0]        entry_id_i,
  input  logic signed [SCORE_W-1:0] entry_score_i,
  input  logic [ID_BITS-1:0]        key_id_i,
  input  logic signed [SCORE_W-1:0] key_score_i,
  output cmp_t                      cmp_o
);

  always_comb begin
    cmp_o.id_eq = (entry_id_i == key_id_i);
    cmp_o.ge    = (entry_score_i >= key_score_i);
    cmp_o.gt    = (key_score_i > entry_score_i);
  end

endmodule

FILE: hw/rtl/tks_table.sv
`timescale 1ns / 1ps

module tks_table import tks_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int ID_BITS = ID_BITS_DEF,
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic [IDX_W-1:0]          rd_addr_i,
  output logic [ID_BITS-1:0]        rd_id_o,
  output logic signed [SCORE_W-1:0] rd_score_o,
  input  logic                      wr_en_i,
  input  logic [IDX_W-1:0]          wr_addr_i,
  input  logic [ID_BITS-1:0]        wr_id_i,
  input  logic signed [SCORE_W-1:0] wr_score_i
);

  logic [ID_BITS-1:0]        id_q    [DEPTH];
  logic signed [SCORE_W-1:0] score_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      id_q[wr_addr_i]    <= wr_id_i;
      score_q[wr_addr_i] <= wr_score_i;
    end
  end

  assign rd_id_o    = id_q[rd_addr_i];
  assign rd_score_o = score_q[rd_addr_i];

endmodule

FILE: hw/rtl/top_k_score_table.sv
`timescale 1ns / 1ps
// Read and clear: the result strobe comes in the cycle after the beat; busy stays low.
// Insert: busy while it scans, decides, evicts the last entry if the table is full,
// shifts and places; a found id that is not raised, or a dropped beat, ends at
// the decide state. The strobe rises as busy falls. The single entry comparator and
// the single table read port make an insert step entry by entry. Results cannot be stalled.
// Reset empties the table; stored ids and scores are not cleared.

module top_k_score_table import tks_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic [ID_BITS-1:0]        player_id_i,
  input  logic signed [SCORE_W-1:0] score_i,
  input  logic [RANK_W-1:0]         read_rank_i,
  output logic                      done_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic [RANK_W-1:0]         rank_o,
  output logic                      evicted_o,
  output logic [ID_BITS-1:0]        out_id_o,
  output logic signed [SCORE_W-1:0] out_score_o
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] idx_m1;
  logic found_q, found_d;
  logic gt_q, gt_d;
  logic ev_q, ev_d;
  logic [ID_BITS-1:0]        ev_id_q, ev_id_d;
  logic signed [SCORE_W-1:0] ev_score_q, ev_score_d;
  logic [ID_BITS-1:0]        key_id_q, key_id_d;
  logic signed [SCORE_W-1:0] key_score_q, key_score_d;

  logic                      res_set;
  logic [STATUS_W-1:0]       res_status;
  logic [RANK_W-1:0]         res_rank;
  logic                      res_ev;
  logic [ID_BITS-1:0]        res_id;
  logic signed [SCORE_W-1:0] res_score;

  logic                      done_q;
  logic [STATUS_W-1:0]       status_q;
  logic [RANK_W-1:0]         rank_q;
  logic                      evicted_q;
  logic [ID_BITS-1:0]        out_id_q;
  logic signed [SCORE_W-1:0] out_score_q;

  logic [IDX_W-1:0]          rd_addr;
  logic [ID_BITS-1:0]        rd_id;
  logic signed [SCORE_W-1:0] rd_score;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [ID_BITS-1:0]        wr_id;
  logic signed [SCORE_W-1:0] wr_score;
  logic [CMP_W-1:0]          rr_ext;
  cmp_t                      cmp;

  tks_table #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .rd_addr_i  (rd_addr),
    .rd_id_o    (rd_id),
    .rd_score_o (rd_score),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_id_i    (wr_id),
    .wr_score_i (wr_score)
  );

  tks_cmp #(
    .ID_BITS (ID_BITS)
  ) u_cmp (
    .entry_id_i    (rd_id),
    .entry_score_i (rd_score),
    .key_id_i      (key_id_q),
    .key_score_i   (key_score_q),
    .cmp_o         (cmp)
  );

  assign busy   = (state_q != S_IDLE);
  assign rr_ext = CMP_W'(read_rank_i);
  assign idx_m1 = idx_q - CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    found_d     = found_q;
    gt_d        = gt_q;
    ev_d        = ev_q;
    ev_id_d     = ev_id_q;
    ev_score_d  = ev_score_q;
    key_id_d    = key_id_q;
    key_score_d = key_score_q;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_id       = key_id_q;
    wr_score    = key_score_q;
    res_set     = 1'b0;
    res_status  = STAT_INSERTED;
    res_rank    = '0;
    res_ev      = 1'b0;
    res_id      = '0;
    res_score   = '0;

    unique case (state_q)
      S_IDLE: begin
        rd_addr = rr_ext[IDX_W-1:0];
        if (start) begin
          case (kind_i)
            KIND_INSERT: begin
              key_id_d    = player_id_i;
              key_score_d = score_i;
              idx_d       = '0;
              pos_d       = '0;
              found_d     = 1'b0;
              gt_d        = 1'b0;
              ev_d        = 1'b0;
              ev_id_d     = '0;
              ev_score_d  = '0;
              state_d     = S_SCAN;
            end
            KIND_READ: begin
              res_set  = 1'b1;
              res_rank = read_rank_i;
              // Valid entries are packed, so a rank below the fill count is held.
              if (rr_ext < CMP_W'(count_q)) begin
                res_status = STAT_READ_OK;
                res_id     = rd_id;
                res_score  = rd_score;
              end else begin
                res_status = STAT_READ_EMPTY;
              end
            end
            KIND_CLEAR: begin
              count_d    = '0;
              res_set    = 1'b1;
              res_status = STAT_CLEARED;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        rd_addr = idx_q[IDX_W-1:0];
        if (idx_q == count_q) begin
          state_d = S_DECIDE;
        end else if (cmp.id_eq) begin
          found_d = 1'b1;
          gt_d    = cmp.gt;
          state_d = S_DECIDE;
        end else begin
          pos_d = pos_q + CNT_W'(cmp.ge);
          idx_d = idx_q + CNT_W'(1);
        end
      end

      S_DECIDE: begin
        if (found_q) begin
          if (gt_q) begin
            state_d = S_SHIFT;
          end else begin
            res_set    = 1'b1;
            res_status = STAT_KEPT;
            res_rank   = RANK_W'(idx_q);
            state_d    = S_IDLE;
          end
        end else if (pos_q == CNT_W'(DEPTH)) begin
          res_set    = 1'b1;
          res_status = STAT_DROPPED;
          res_rank   = RANK_W'(DEPTH);
          state_d    = S_IDLE;
        end else if (count_q == CNT_W'(DEPTH)) begin
          state_d = S_EVICT;
        end else begin
          // The scan index already equals the fill count: the first free slot.
          state_d = S_SHIFT;
        end
      end

      S_EVICT: begin
        rd_addr    = IDX_W'(DEPTH - 1);
        ev_d       = 1'b1;
        ev_id_d    = rd_id;
        ev_score_d = rd_score;
        idx_d      = CNT_W'(DEPTH - 1);
        state_d    = S_SHIFT;
      end

      S_SHIFT: begin
        rd_addr = idx_m1[IDX_W-1:0];
        if (idx_q == pos_q) begin
          state_d = S_PLACE;
        end else begin
          wr_en    = 1'b1;
          wr_addr  = idx_q[IDX_W-1:0];
          wr_id    = rd_id;
          wr_score = rd_score;
          idx_d    = idx_m1;
        end
      end

      S_PLACE: begin
        wr_en      = 1'b1;
        wr_addr    = pos_q[IDX_W-1:0];
        res_set    = 1'b1;
        res_status = found_q ? STAT_RAISED : STAT_INSERTED;
        res_rank   = RANK_W'(pos_q);
        res_ev     = ev_q;
        res_id     = ev_id_q;
        res_score  = ev_score_q;
        if (!found_q && !ev_q) begin
          count_d = count_q + CNT_W'(1);
        end
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= res_set;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    pos_q       <= pos_d;
    found_q     <= found_d;
    gt_q        <= gt_d;
    ev_q        <= ev_d;
    ev_id_q     <= ev_id_d;
    ev_score_q  <= ev_score_d;
    key_id_q    <= key_id_d;
    key_score_q <= key_score_d;
    if (res_set) begin
      status_q    <= res_status;
      rank_q      <= res_rank;
      evicted_q   <= res_ev;
      out_id_q    <= res_id;
      out_score_q <= res_score;
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign rank_o      = rank_q;
  assign evicted_o   = evicted_q;
  assign out_id_o    = out_id_q;
  assign out_score_o = out_score_q;

endmodule

FILE: sim/tb_top_k_score_table.sv
`timescale 1ns / 1ps

module tb_top_k_score_table;
  import tks_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int ID_BITS    = ID_BITS_DEF;
  localparam int QUIET_MAX  = 1000;
  localparam int TAIL_WAIT  = 2 * DEPTH + 10;
  // The fourth kind code has no name in the package; the block ignores it.
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0]       status;
    logic [RANK_W-1:0]         rank;
    logic                      evicted;
    logic [ID_BITS-1:0]        out_id;
    logic signed [SCORE_W-1:0] out_score;
  } table_result_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      start       = 1'b0;
  logic                      busy;
  logic [KIND_W-1:0]         kind_i      = KIND_INSERT;
  logic [ID_BITS-1:0]        player_id_i = '0;
  logic signed [SCORE_W-1:0] score_i     = '0;
  logic [RANK_W-1:0]         read_rank_i = '0;
  logic                      done_o;
  logic [STATUS_W-1:0]       status_o;
  logic [RANK_W-1:0]         rank_o;
  logic                      evicted_o;
  logic [ID_BITS-1:0]        out_id_o;
  logic signed [SCORE_W-1:0] out_score_o;

  // Predicted contents of the ranked table.
  logic                      tbl_valid [DEPTH];
  logic [ID_BITS-1:0]        tbl_id    [DEPTH];
  logic signed [SCORE_W-1:0] tbl_score [DEPTH];

  table_result_t pending_results [$];
  logic [ID_BITS-1:0] id_pool [8];
  int gap_pct     = 0;
  int fail_count  = 0;
  int quiet_count = 0;

  top_k_score_table #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .player_id_i (player_id_i),
    .score_i     (score_i),
    .read_rank_i (read_rank_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .rank_o      (rank_o),
    .evicted_o   (evicted_o),
    .out_id_o    (out_id_o),
    .out_score_o (out_score_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic table_result_t rank_table_apply(input logic [KIND_W-1:0] k,
                                                     input logic [ID_BITS-1:0] id,
                                                     input logic signed [SCORE_W-1:0] sc,
                                                     input logic [RANK_W-1:0] rr);
    table_result_t r;
    int n;
    int found;
    int pos;
    int last;
    r.status    = '0;
    r.rank      = '0;
    r.evicted   = 1'b0;
    r.out_id    = '0;
    r.out_score = '0;
    n = 0;
    found = -1;
    pos = 0;
    for (int i = 0; i < DEPTH; i++) if (tbl_valid[i]) n++;
    case (k)
      KIND_INSERT: begin
        for (int i = 0; i < n; i++) if (found < 0 && tbl_id[i] == id) found = i;
        if (found >= 0) begin
          if (sc > tbl_score[found]) begin
            for (int j = 0; j < found; j++) if (tbl_score[j] >= sc) pos++;
            for (int j = found; j > pos; j--) begin
              tbl_id[j]    = tbl_id[j-1];
              tbl_score[j] = tbl_score[j-1];
            end
            tbl_id[pos]    = id;
            tbl_score[pos] = sc;
            r.status = STAT_RAISED;
            r.rank   = pos[RANK_W-1:0];
          end else begin
            r.status = STAT_KEPT;
            r.rank   = found[RANK_W-1:0];
          end
        end else begin
          for (int j = 0; j < n; j++) if (tbl_score[j] >= sc) pos++;
          if (pos >= DEPTH) begin
            r.status = STAT_DROPPED;
            r.rank   = DEPTH[RANK_W-1:0];
          end else begin
            last = n;
            if (n == DEPTH) begin
              r.evicted   = 1'b1;
              r.out_id    = tbl_id[DEPTH-1];
              r.out_score = tbl_score[DEPTH-1];
              last = DEPTH - 1;
            end
            for (int j = last; j > pos; j--) begin
              tbl_id[j]    = tbl_id[j-1];
              tbl_score[j] = tbl_score[j-1];
            end
            tbl_id[pos]     = id;
            tbl_score[pos]  = sc;
            tbl_valid[last] = 1'b1;
            r.status = STAT_INSERTED;
            r.rank   = pos[RANK_W-1:0];
          end
        end
      end
      KIND_READ: begin
        r.rank = rr;
        if (rr < DEPTH && tbl_valid[rr]) begin
          r.status    = STAT_READ_OK;
          r.out_id    = tbl_id[rr];
          r.out_score = tbl_score[rr];
        end else begin
          r.status = STAT_READ_EMPTY;
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
        r.status = STAT_CLEARED;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offers one beat, optionally after an idle gap, and records what it should produce.
  task automatic issue_op(input logic [KIND_W-1:0] k, input logic [ID_BITS-1:0] id,
                          input logic signed [SCORE_W-1:0] sc, input logic [RANK_W-1:0] rr);
    table_result_t want;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    start       <= 1'b1;
    kind_i      <= k;
    player_id_i <= id;
    score_i     <= sc;
    read_rank_i <= rr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    want = rank_table_apply(k, id, sc, rr);
    if (k != KIND_NONE) pending_results.push_back(want);
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    table_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no outstanding item");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (rank_o !== want.rank) begin
          $error("rank: expected %0d, got %0d", want.rank, rank_o);
          fail_count++;
        end
        if (evicted_o !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, evicted_o);
          fail_count++;
        end
        if (out_id_o !== want.out_id) begin
          $error("out_id: expected %0h, got %0h", want.out_id, out_id_o);
          fail_count++;
        end
        if (out_score_o !== want.out_score) begin
          $error("out_score: expected %0d, got %0d", want.out_score, out_score_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_count <= 0;
    else quiet_count <= quiet_count + 1;
  end

  initial begin
    while (quiet_count < QUIET_MAX) @(posedge clk_i);
    $display("top_k_score_table verification failed");
    $finish;
  end

  task automatic test_empty_table_reads();
    issue_op(KIND_READ, 16'h0000, 32'sd0, 3'd0);
    issue_op(KIND_READ, 16'hFFFF, 32'sd0, 3'd7);
  endtask

  // Ties land after the entries already holding the same score.
  task automatic test_fill_and_ties();
    issue_op(KIND_INSERT, 16'h0064, 32'sd0, 3'd0);
    issue_op(KIND_INSERT, 16'h0065, 32'sd0, 3'd0);
    issue_op(KIND_INSERT, 16'h0066, 32'h7FFF_FFFF, 3'd0);
    issue_op(KIND_INSERT, 16'h0067, 32'h8000_0000, 3'd0);
    issue_op(KIND_INSERT, 16'h0068, -32'sd1, 3'd0);
    issue_op(KIND_READ, 16'h0000, 32'sd0, 3'd4);
  endtask

  task automatic test_evict_and_drop();
    issue_op(KIND_INSERT, 16'h0069, 32'h8000_0000, 3'd0);
    issue_op(KIND_INSERT, 16'h006A, 32'sd0, 3'd0);
    issue_op(KIND_INSERT, 16'h006B, -32'sd1, 3'd0);
  endtask

  task automatic test_score_updates();
    issue_op(KIND_INSERT, 16'h0068, 32'sd5, 3'd0);
    issue_op(KIND_INSERT, 16'h0064, 32'sd0, 3'd0);
    issue_op(KIND_INSERT, 16'h0064, -32'sd7, 3'd0);
    issue_op(KIND_INSERT, 16'h0066, 32'h7FFF_FFFF, 3'd0);
    issue_op(KIND_INSERT, 16'h006A, 32'h7FFF_FFFF, 3'd0);
    issue_op(KIND_READ, 16'h0000, 32'sd0, 3'd1);
    issue_op(KIND_READ, 16'h0000, 32'sd0, 3'd5);
  endtask

  task automatic test_clear_and_unused_kind();
    issue_op(KIND_NONE, 16'h0064, 32'sd9, 3'd0);
    issue_op(KIND_CLEAR, 16'h0000, 32'sd0, 3'd0);
    issue_op(KIND_READ, 16'h0000, 32'sd0, 3'd0);
    issue_op(KIND_INSERT, 16'hFFFF, 32'h7FFF_FFFF, 3'd0);
    wait_results_drained();
  endtask

  // Mostly inserts from a small id pool so that updates, ties and evictions are common.
  task automatic test_random_traffic(input int idle_pct, input int count);
    logic [KIND_W-1:0]         k;
    logic [ID_BITS-1:0]        id;
    logic signed [SCORE_W-1:0] sc;
    logic [RANK_W-1:0]         rr;
    int roll;
    int idx;
    gap_pct = idle_pct;
    for (int i = 0; i < 8; i++) id_pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 62) k = KIND_INSERT;
      else if (roll < 92) k = KIND_READ;
      else if (roll < 96) k = KIND_CLEAR;
      else k = KIND_NONE;
      id = ($urandom_range(99) < 75) ? id_pool[$urandom_range(7)] : ID_BITS'($urandom);
      roll = $urandom_range(99);
      if (roll < 35) begin
        sc = int'($urandom_range(8)) - 4;
      end else if (roll < 60) begin
        sc = $urandom;
      end else if (roll < 75) begin
        case ($urandom_range(3))
          0: sc = 32'h7FFF_FFFF;
          1: sc = 32'h8000_0000;
          2: sc = 32'sd0;
          default: sc = -32'sd1;
        endcase
      end else begin
        idx = $urandom_range(DEPTH - 1);
        sc = tbl_valid[idx] ? tbl_score[idx] + int'($urandom_range(2)) - 1
                            : int'($urandom_range(8)) - 4;
      end
      rr = ($urandom_range(99) < 80) ? RANK_W'($urandom_range(DEPTH - 1))
                                     : RANK_W'($urandom_range(7));
      issue_op(k, id, sc, rr);
      if ($urandom_range(99) == 0) wait_results_drained();
    end
    wait_results_drained();
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_id[i]    = '0;
      tbl_score[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table_reads();
    test_fill_and_ties();
    test_evict_and_drop();
    test_score_updates();
    test_clear_and_unused_kind();
    test_random_traffic(0, 320);
    test_random_traffic(70, 320);
    test_random_traffic(14, 310);
    wait_results_drained();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("top_k_score_table verification clean");
    end else begin
      $display("top_k_score_table verification failed");
    end
    $finish;
  end

endmodule
